>>> rtl/core/pfst_pkg.sv
// ----------------------------------------------------------------------------
// pfst_pkg
// shared constants, types and functions for the peer failure status table
// ----------------------------------------------------------------------------
`default_nettype none
package pfst_pkg;
    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;
    localparam int HASH_W      = 32;
    localparam int KEY_W       = 64 + 64 + 17;
    localparam int ENT_W       = KEY_W + 3 + 32 + 32;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_UNSET = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FADE = 3'd1;
    localparam logic [2:0] MONITOR_RESET = 3'd4;
    localparam logic [0:0] REG_MONITOR = 1'b0;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [16:0] key_pf;
        logic [2:0]  status;
        logic [31:0] expire;
        logic [31:0] fade;
    } t_entry;

    // one djb xor step
    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
        hash_step = ((h << 5) + h) ^ {24'd0, b};
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        add_sat = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/pfst_ram.sv
// ----------------------------------------------------------------------------
// pfst_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module pfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/peer_failure_status_table.sv
// ----------------------------------------------------------------------------
// peer_failure_status_table
// hashed table of failing peers with set / unset / get and expiry rules
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  input    | i_valid / o_stall   | opcode, key, status, duration, time
//  result   | o_valid / i_stall   | cur_status, hit, table_full
//  config   | apb                 | monitor_code at 0x0
//
// a transaction is taken in the idle state, then each hash byte passes through
// the shared djb step (7 bytes for ipv4, 19 for ipv6), each way gets a compare
// pass (ram read, compare), a set that finds neither its key nor a free way
// runs a dead-way search (read, check), a set or unset that updates an entry
// passes a write state, and the result state ends it, held by result stalls.
// reset clears all way valid bits at once; no clearing pass.
// the result is held in an output register until taken; no new transaction
// is taken until then.
`default_nettype none
module peer_failure_status_table
    import pfst_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [63:0] i_addr_high,
    input  wire logic [63:0] i_addr_low,
    input  wire logic [15:0] i_peer_port,
    input  wire logic        i_is_v6,
    input  wire logic [2:0]  i_req_status,
    input  wire logic [31:0] i_duration_s,
    input  wire logic [31:0] i_now_s,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_cur_status,
    output logic             o_hit,
    output logic             o_table_full,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int AW = $clog2(ENTRIES) > 0 ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {S_IDLE, S_HASH, S_RD, S_CMP, S_RD2, S_CMP2, S_WR, S_OUT}
        t_state;

    t_state r_state;
    logic [2:0]  r_monitor;
    logic [1:0]  r_op;
    logic [63:0] r_hi, r_lo;
    logic [16:0] r_pf;
    logic [2:0]  r_st;
    logic [31:0] r_dur, r_now, r_hash;
    logic [4:0]  r_bcnt;
    logic [WW:0] r_way;
    logic [WW-1:0] r_sel;
    logic        r_found, r_got;
    logic [ENTRIES-1:0] r_vld;
    logic [BW-1:0] r_bucket;
    t_entry      r_ent;
    logic [2:0]  r_cur;
    logic        r_hit, r_full;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;

    pfst_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] ent_addr(input logic [BW-1:0] b, input logic [WW-1:0] w);
        logic [31:0] a;
        a = 32'(b) * 32'(WAYS) + 32'(w);
        ent_addr = a[AW-1:0];
    endfunction

    // hash byte selection, one per cycle
    logic [7:0] hbyte;
    always_comb begin
        hbyte = 8'd0;
        if (r_bcnt == 5'd0) hbyte = {7'd0, r_pf[16]};
        else if (r_bcnt == 5'd1) hbyte = r_pf[15:8];
        else if (r_bcnt == 5'd2) hbyte = r_pf[7:0];
        else if (r_bcnt < 5'd11) hbyte = r_hi[8*(10 - r_bcnt) +: 8];
        else hbyte = r_lo[8*(18 - r_bcnt) +: 8];
        if (!r_pf[16] && r_bcnt >= 5'd3) hbyte = r_hi[8*(6 - r_bcnt) +: 8];
    end
    wire [4:0] last_byte = r_pf[16] ? 5'd18 : 5'd6;

    // entry view of the read word
    wire [WW-1:0] cur_way = r_way[WW-1:0];
    wire rd_valid = r_vld[ent_addr(r_bucket, cur_way)];
    wire key_eq = ram_rdata.key_high == r_hi && ram_rdata.key_low == r_lo &&
                  ram_rdata.key_pf == r_pf;

    function automatic logic expired(input t_entry e, input logic [2:0] mon,
                                     input logic [31:0] now);
        expired = (e.status != mon) && (now >= e.expire);
    endfunction
    function automatic logic fade_live(input t_entry e, input logic [31:0] now);
        fade_live = (e.fade != 32'd0) && (now < e.fade);
    endfunction
    function automatic logic [2:0] effective(input t_entry e, input logic [2:0] mon,
                                             input logic [31:0] now);
        if (!expired(e, mon, now)) effective = e.status;
        else if (fade_live(e, now)) effective = ST_FADE;
        else effective = ST_OK;
    endfunction

    // read-modify-write of the found or chosen entry
    t_entry n_ent;
    logic   n_keep;
    logic [31:0] sum;
    always_comb begin
        n_ent = r_ent;
        n_keep = 1'b1;
        sum = add_sat(r_now, r_dur);
        if (!r_found) begin
            n_ent.key_high = r_hi;
            n_ent.key_low = r_lo;
            n_ent.key_pf = r_pf;
            n_ent.status = r_st;
            n_ent.expire = sum;
            n_ent.fade = 32'd0;
        end else if (r_op == OP_SET) begin
            if (expired(r_ent, r_monitor, r_now) || r_st == r_ent.status) begin
                n_ent.expire = sum;
                n_ent.status = r_st;
            end else if (r_st == ST_FADE) begin
                n_ent.fade = sum;
            end else if (r_ent.status == ST_FADE) begin
                n_ent.fade = r_ent.expire;
                n_ent.expire = sum;
                n_ent.status = r_st;
            end else if (r_st > r_ent.status) begin
                n_ent.expire = sum;
                n_ent.status = r_st;
            end
        end else begin
            if (r_st == ST_FADE) n_ent.fade = 32'd0;
            if (!(r_st == ST_OK || r_ent.status == r_st) &&
                !expired(r_ent, r_monitor, r_now)) begin
                n_keep = 1'b1;
            end else if (r_st != ST_OK && fade_live(n_ent, r_now)) begin
                n_ent.status = ST_FADE;
                n_ent.expire = n_ent.fade;
                n_ent.fade = 32'd0;
            end else begin
                n_keep = 1'b0;
            end
        end
    end

    wire is_set = (r_op == OP_SET) && (r_st != ST_OK);
    wire is_unset = (r_op == OP_UNSET);

    always_comb begin
        ram_we = (r_state == S_WR) && n_keep;
        ram_waddr = ent_addr(r_bucket, r_sel);
        ram_wdata = n_ent;
        ram_raddr = ent_addr(r_bucket, cur_way);
    end

    // bit 0 of paddr is ignored
    wire cfg_wr = psel && penable && pwrite && paddr[1:1] == REG_MONITOR;
    assign pready = 1'b1;
    assign prdata = (paddr[1:1] == REG_MONITOR) ? {29'd0, r_monitor} : 32'd0;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_cur_status = r_cur;
    assign o_hit = r_hit;
    assign o_table_full = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_monitor <= MONITOR_RESET;
            r_vld <= '0;
        end else begin
            if (cfg_wr) r_monitor <= pwdata[2:0];
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_opcode;
                        r_hi <= i_is_v6 ? i_addr_high : {32'd0, i_addr_high[31:0]};
                        r_lo <= i_is_v6 ? i_addr_low : 64'd0;
                        r_pf <= {i_is_v6, i_peer_port};
                        r_st <= i_req_status;
                        r_dur <= i_duration_s;
                        r_now <= i_now_s;
                        r_hash <= 32'd5381;
                        r_bcnt <= 5'd0;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    r_hash <= hash_step(r_hash, hbyte);
                    r_bcnt <= r_bcnt + 5'd1;
                    if (r_bcnt == last_byte) begin
                        r_bucket <= BW'(hash_step(r_hash, hbyte) % 32'(BUCKETS));
                        r_way <= '0;
                        r_found <= 1'b0;
                        r_got <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (rd_valid && key_eq) begin
                        r_found <= 1'b1;
                        r_sel <= cur_way;
                        r_ent <= ram_rdata;
                        r_state <= (is_set || is_unset) ? S_WR : S_OUT;
                        r_hit <= 1'b1;
                        r_full <= 1'b0;
                        r_cur <= effective(ram_rdata, r_monitor, r_now);
                    end else begin
                        if (!rd_valid && !r_got) begin
                            r_got <= 1'b1;
                            r_sel <= cur_way;
                        end
                        if (r_way == (WW+1)'(WAYS - 1)) begin
                            r_hit <= 1'b0;
                            r_cur <= ST_OK;
                            r_full <= 1'b0;
                            if (!is_set) r_state <= S_OUT;
                            else if (r_got || !rd_valid) r_state <= S_WR;
                            else begin
                                r_way <= '0;
                                r_state <= S_RD2;
                            end
                        end else begin
                            r_way <= r_way + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD2: r_state <= S_CMP2;
                S_CMP2: begin
                    // dead way search: effective status ok
                    if (effective(ram_rdata, r_monitor, r_now) == ST_OK) begin
                        r_sel <= cur_way;
                        r_state <= S_WR;
                    end else if (r_way == (WW+1)'(WAYS - 1)) begin
                        r_full <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_way <= r_way + 1'b1;
                        r_state <= S_RD2;
                    end
                end
                S_WR: begin
                    r_vld[ent_addr(r_bucket, r_sel)] <= n_keep;
                    r_cur <= n_keep ? effective(n_ent, r_monitor, r_now) : ST_OK;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/pfst_checker.sv
// ----------------------------------------------------------------------------
// pfst_checker
// port level checks on the peer failure status table
// ----------------------------------------------------------------------------
`default_nettype none
module pfst_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_cur_status,
    input wire logic       o_hit,
    input wire logic       o_table_full
);
    // a failed set reports nothing found and ok status
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> !o_hit && o_cur_status == 3'd0)
        else $error("table_full with hit or status");
    // no new transaction is taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
    // an accepted transaction does not produce a result in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("result too early");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cur_status))
        else $error("stalled result changed");
endmodule

bind peer_failure_status_table pfst_checker u_pfst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_cur_status(o_cur_status),
    .o_hit(o_hit), .o_table_full(o_table_full)
);
`default_nettype wire
